[hdl/drds_pkg.sv]
// Shared constants, codes and types of the dual-range decimating sampler.
`default_nettype none
package drds_pkg;

   localparam int QUEUE_DEPTH    = 1024;
   localparam int QADDR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int QWIDE_BITS     = QCOUNT_BITS + 1;

   localparam int MAX_DECIMATION = 1024;
   localparam int PAIR_BITS      = $clog2(MAX_DECIMATION + 1);

   localparam int SAMPLE_BITS    = 12;
   localparam int SUM_BITS       = 22;
   localparam int GAIN_BITS      = 32;
   localparam int PROD_BITS      = SUM_BITS + GAIN_BITS;
   localparam int VALUE_BITS     = 56;
   localparam int TOTAL_BITS     = 32;
   localparam int DEC_BITS       = 11;
   localparam int REQ_BITS       = 2;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam int OUTQ_DEPTH     = 8;
   localparam int OUTQ_PTR_BITS  = $clog2(OUTQ_DEPTH);
   localparam int CREDIT_BITS    = $clog2(OUTQ_DEPTH + 1);

   localparam logic [DEC_BITS-1:0]    DECIMATION_RESET = 11'd1;
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET  = 12'hff0;

   localparam logic [REQ_BITS-1:0] REQ_SAMPLE = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_POP    = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_START  = 2'd2;
   localparam logic [REQ_BITS-1:0] REQ_STOP   = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECIMATION   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_VALUES = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_HIGH    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_LOW     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD    = 3'd4;

   typedef struct packed {
      logic [GAIN_BITS-1:0] gain_high;
      logic [GAIN_BITS-1:0] gain_low;
   } cfg_type;

   typedef struct packed {
      logic                  vld;
      logic [QADDR_BITS-1:0] addr;
      logic [SUM_BITS-1:0]   sum_high;
      logic [SUM_BITS-1:0]   sum_low;
   } push_type;

   typedef struct packed {
      logic                  vld;
      logic [QADDR_BITS-1:0] addr;
      logic                  empty;
      logic                  overflow;
      logic                  done;
   } pop_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  queue_empty;
      logic                  overflow_seen;
      logic                  run_complete;
   } entry_type;

   typedef struct packed {
      logic      vld;
      entry_type entry;
   } result_type;

endpackage
`default_nettype wire

[hdl/drds_req_if.sv]
// Request channel of the sampler: valid, ready and one request item.
`default_nettype none
interface drds_req_if;
   logic                                valid;
   logic                                ready;
   logic [drds_pkg::REQ_BITS-1:0]       req_type;
   logic [drds_pkg::SAMPLE_BITS-1:0]    high_sample;
   logic [drds_pkg::SAMPLE_BITS-1:0]    low_sample;

   modport source (output valid, req_type, high_sample, low_sample, input ready);
   modport sink (input valid, req_type, high_sample, low_sample, output ready);
endinterface
`default_nettype wire

[hdl/drds_rsp_if.sv]
// Response channel of the sampler: valid, ready and one popped item.
`default_nettype none
interface drds_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [drds_pkg::VALUE_BITS-1:0]   value;
   logic                              queue_empty;
   logic                              overflow_seen;
   logic                              run_complete;

   modport source (output valid, value, queue_empty, overflow_seen, run_complete,
                   input ready);
   modport sink (input valid, value, queue_empty, overflow_seen, run_complete,
                 output ready);
endinterface
`default_nettype wire

[hdl/drds_ctrl.sv]
// Control registers, range selection, accumulation and queue bookkeeping.
`default_nettype none
module drds_ctrl (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [drds_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [drds_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                 accept,
   input  wire logic [drds_pkg::REQ_BITS-1:0]        req_type,
   input  wire logic [drds_pkg::SAMPLE_BITS-1:0]     high_sample,
   input  wire logic [drds_pkg::SAMPLE_BITS-1:0]     low_sample,
   output drds_pkg::cfg_type                         cfg,
   output drds_pkg::push_type                        push,
   output drds_pkg::pop_type                         pop
);

   logic [drds_pkg::DEC_BITS-1:0]     decimation_ff, decimation_in;
   logic [drds_pkg::TOTAL_BITS-1:0]   total_values_ff, total_values_in;
   logic [drds_pkg::GAIN_BITS-1:0]    gain_high_ff, gain_high_in;
   logic [drds_pkg::GAIN_BITS-1:0]    gain_low_ff, gain_low_in;
   logic [drds_pkg::SAMPLE_BITS-1:0]  threshold_ff, threshold_in;

   logic [drds_pkg::SUM_BITS-1:0]     high_sum_ff, high_sum_in;
   logic [drds_pkg::SUM_BITS-1:0]     low_sum_ff, low_sum_in;
   logic [drds_pkg::PAIR_BITS-1:0]    pair_count_ff, pair_count_in;
   logic [drds_pkg::QADDR_BITS-1:0]   queue_head_ff, queue_head_in;
   logic [drds_pkg::QCOUNT_BITS-1:0]  queue_count_ff, queue_count_in;
   logic                              overflow_ff, overflow_in;
   logic [drds_pkg::TOTAL_BITS-1:0]   produced_ff, produced_in;
   logic                              running_ff, running_in;
   drds_pkg::push_type                push_ff, push_in;
   drds_pkg::pop_type                 pop_ff, pop_in;

   always_comb begin
      decimation_in   = decimation_ff;
      total_values_in = total_values_ff;
      gain_high_in    = gain_high_ff;
      gain_low_in     = gain_low_ff;
      threshold_in    = threshold_ff;
      if (csr_we) begin
         case (csr_index)
            drds_pkg::CSR_DECIMATION:   decimation_in   = csr_wdata[drds_pkg::DEC_BITS-1:0];
            drds_pkg::CSR_TOTAL_VALUES: total_values_in = csr_wdata[drds_pkg::TOTAL_BITS-1:0];
            drds_pkg::CSR_GAIN_HIGH:    gain_high_in    = csr_wdata[drds_pkg::GAIN_BITS-1:0];
            drds_pkg::CSR_GAIN_LOW:     gain_low_in     = csr_wdata[drds_pkg::GAIN_BITS-1:0];
            drds_pkg::CSR_THRESHOLD:    threshold_in    = csr_wdata[drds_pkg::SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [drds_pkg::PAIR_BITS-1:0]  eff_decimation;
      logic [drds_pkg::PAIR_BITS-1:0]  pair_next;
      logic [drds_pkg::SUM_BITS-1:0]   high_add;
      logic [drds_pkg::SUM_BITS-1:0]   low_add;
      logic [drds_pkg::QWIDE_BITS-1:0] rd_wide;
      logic [drds_pkg::TOTAL_BITS-1:0] produced_next;

      high_sum_in    = high_sum_ff;
      low_sum_in     = low_sum_ff;
      pair_count_in  = pair_count_ff;
      queue_head_in  = queue_head_ff;
      queue_count_in = queue_count_ff;
      overflow_in    = overflow_ff;
      produced_in    = produced_ff;
      running_in     = running_ff;
      push_in        = '0;
      pop_in         = '0;

      if (decimation_ff == '0) begin
         eff_decimation = drds_pkg::PAIR_BITS'(1);
      end else if (32'(decimation_ff) > 32'(drds_pkg::MAX_DECIMATION)) begin
         eff_decimation = drds_pkg::PAIR_BITS'(drds_pkg::MAX_DECIMATION);
      end else begin
         eff_decimation = drds_pkg::PAIR_BITS'(decimation_ff);
      end
      pair_next     = pair_count_ff + 1'b1;
      produced_next = produced_ff + 1'b1;

      high_add = high_sum_ff;
      low_add  = low_sum_ff;
      if (low_sample < threshold_ff) begin
         low_add = low_sum_ff + drds_pkg::SUM_BITS'(low_sample);
      end else begin
         high_add = high_sum_ff + drds_pkg::SUM_BITS'(high_sample);
      end

      rd_wide = drds_pkg::QWIDE_BITS'(queue_head_ff)
              + drds_pkg::QWIDE_BITS'(drds_pkg::QUEUE_DEPTH)
              - drds_pkg::QWIDE_BITS'(queue_count_ff);
      if (rd_wide >= drds_pkg::QWIDE_BITS'(drds_pkg::QUEUE_DEPTH)) begin
         rd_wide = rd_wide - drds_pkg::QWIDE_BITS'(drds_pkg::QUEUE_DEPTH);
      end

      if (accept) begin
         case (req_type)
            drds_pkg::REQ_SAMPLE: begin
               if (running_ff) begin
                  high_sum_in   = high_add;
                  low_sum_in    = low_add;
                  pair_count_in = pair_next;
                  if (pair_next >= eff_decimation) begin
                     high_sum_in   = '0;
                     low_sum_in    = '0;
                     pair_count_in = '0;
                     if (queue_count_ff >= drds_pkg::QCOUNT_BITS'(drds_pkg::QUEUE_DEPTH)) begin
                        overflow_in = 1'b1;
                     end else begin
                        push_in.vld      = 1'b1;
                        push_in.addr     = queue_head_ff;
                        push_in.sum_high = high_add;
                        push_in.sum_low  = low_add;
                        if (queue_head_ff ==
                            drds_pkg::QADDR_BITS'(drds_pkg::QUEUE_DEPTH - 1)) begin
                           queue_head_in = '0;
                        end else begin
                           queue_head_in = queue_head_ff + 1'b1;
                        end
                        queue_count_in = queue_count_ff + 1'b1;
                        produced_in    = produced_next;
                        if (produced_next >= total_values_ff) begin
                           running_in = 1'b0;
                        end
                     end
                  end
               end
            end
            drds_pkg::REQ_POP: begin
               pop_in.vld      = 1'b1;
               pop_in.addr     = rd_wide[drds_pkg::QADDR_BITS-1:0];
               pop_in.empty    = (queue_count_ff == '0);
               pop_in.overflow = overflow_ff;
               pop_in.done     = (produced_ff != '0) && (produced_ff >= total_values_ff);
               if (queue_count_ff != '0) begin
                  queue_count_in = queue_count_ff - 1'b1;
               end
            end
            drds_pkg::REQ_START: begin
               high_sum_in    = '0;
               low_sum_in     = '0;
               pair_count_in  = '0;
               produced_in    = '0;
               queue_head_in  = '0;
               queue_count_in = '0;
               overflow_in    = 1'b0;
               running_in     = 1'b1;
            end
            drds_pkg::REQ_STOP: begin
               running_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff   <= drds_pkg::DECIMATION_RESET;
         total_values_ff <= '0;
         gain_high_ff    <= '0;
         gain_low_ff     <= '0;
         threshold_ff    <= drds_pkg::THRESHOLD_RESET;
         high_sum_ff     <= '0;
         low_sum_ff      <= '0;
         pair_count_ff   <= '0;
         queue_head_ff   <= '0;
         queue_count_ff  <= '0;
         overflow_ff     <= 1'b0;
         produced_ff     <= '0;
         running_ff      <= 1'b0;
         push_ff         <= '0;
         pop_ff          <= '0;
      end else begin
         decimation_ff   <= decimation_in;
         total_values_ff <= total_values_in;
         gain_high_ff    <= gain_high_in;
         gain_low_ff     <= gain_low_in;
         threshold_ff    <= threshold_in;
         high_sum_ff     <= high_sum_in;
         low_sum_ff      <= low_sum_in;
         pair_count_ff   <= pair_count_in;
         queue_head_ff   <= queue_head_in;
         queue_count_ff  <= queue_count_in;
         overflow_ff     <= overflow_in;
         produced_ff     <= produced_in;
         running_ff      <= running_in;
         push_ff         <= push_in;
         pop_ff          <= pop_in;
      end
   end

   assign cfg.gain_high = gain_high_ff;
   assign cfg.gain_low  = gain_low_ff;
   assign push          = push_ff;
   assign pop           = pop_ff;

endmodule
`default_nettype wire

[hdl/drds_store.sv]
// Scaling pipeline and value queue memory with its pop read path.
`default_nettype none
module drds_store (
   input  wire logic            clock,
   input  wire logic            reset,
   input  drds_pkg::cfg_type    cfg,
   input  drds_pkg::push_type   push,
   input  drds_pkg::pop_type    pop,
   output drds_pkg::result_type result
);

   logic [drds_pkg::VALUE_BITS-1:0] queue_mem [drds_pkg::QUEUE_DEPTH];

   logic                            prod_vld_ff;
   logic [drds_pkg::QADDR_BITS-1:0] prod_addr_ff;
   logic [drds_pkg::PROD_BITS-1:0]  prod_high_ff;
   logic [drds_pkg::PROD_BITS-1:0]  prod_low_ff;
   logic [drds_pkg::VALUE_BITS-1:0] wr_value;

   drds_pkg::pop_type               pop_p2_ff;
   drds_pkg::pop_type               pop_p3_ff;
   logic [drds_pkg::VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         pop_p2_ff   <= '0;
         pop_p3_ff   <= '0;
      end else begin
         prod_vld_ff <= push.vld;
         pop_p2_ff   <= pop;
         pop_p3_ff   <= pop_p2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_addr_ff <= push.addr;
      prod_high_ff <= drds_pkg::PROD_BITS'(push.sum_high) * drds_pkg::PROD_BITS'(cfg.gain_high);
      prod_low_ff  <= drds_pkg::PROD_BITS'(push.sum_low) * drds_pkg::PROD_BITS'(cfg.gain_low);
   end

   assign wr_value = drds_pkg::VALUE_BITS'(prod_high_ff) + drds_pkg::VALUE_BITS'(prod_low_ff);

   always_ff @(posedge clock) begin
      if (prod_vld_ff) begin
         queue_mem[prod_addr_ff] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= queue_mem[pop_p2_ff.addr];
   end

   always_comb begin
      result                     = '0;
      result.vld                 = pop_p3_ff.vld;
      result.entry.value         = pop_p3_ff.empty ? '0 : rd_data_ff;
      result.entry.queue_empty   = pop_p3_ff.empty;
      result.entry.overflow_seen = pop_p3_ff.overflow;
      result.entry.run_complete  = pop_p3_ff.done;
   end

endmodule
`default_nettype wire

[hdl/drds_outq.sv]
// Response queue with credit count: holds popped items until taken.
`default_nettype none
module drds_outq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  drds_pkg::result_type            result,
   input  wire logic                       credit_take,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output drds_pkg::entry_type             rsp_entry,
   output logic                            room
);

   drds_pkg::entry_type                slot_ff [drds_pkg::OUTQ_DEPTH];
   logic [drds_pkg::OUTQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [drds_pkg::OUTQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [drds_pkg::CREDIT_BITS-1:0]   occ_ff, occ_in;
   logic [drds_pkg::CREDIT_BITS-1:0]   credit_ff, credit_in;
   logic                               give;

   assign rsp_valid = (occ_ff != '0);
   assign rsp_entry = slot_ff[rd_ptr_ff];
   assign give      = rsp_valid && rsp_ready;
   assign room      = (credit_ff < drds_pkg::CREDIT_BITS'(drds_pkg::OUTQ_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      credit_in = credit_ff;
      if (result.vld) begin
         if (wr_ptr_ff == drds_pkg::OUTQ_PTR_BITS'(drds_pkg::OUTQ_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (give) begin
         if (rd_ptr_ff == drds_pkg::OUTQ_PTR_BITS'(drds_pkg::OUTQ_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      occ_in    = occ_ff + drds_pkg::CREDIT_BITS'(result.vld) - drds_pkg::CREDIT_BITS'(give);
      credit_in = credit_ff + drds_pkg::CREDIT_BITS'(credit_take)
                - drds_pkg::CREDIT_BITS'(give);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.vld) begin
         slot_ff[wr_ptr_ff] <= result.entry;
      end
   end

endmodule
`default_nettype wire

[hdl/dual_range_decimating_sampler.sv]
// Top level of the dual-range decimating sampler.
//
//   channel   dir   carries
//   req_if    in    req_type, high_sample, low_sample
//   rsp_if    out   value, queue_empty, overflow_seen, run_complete
//   csr_*     in    write enable, register index, write data
//
// One request item is taken every cycle while ready is high. A pop item passes
// through the control pop register, the store's pop_p2 and pop_p3 registers and
// the registered read port of the 1024-entry queue memory to the response queue.
// Up to eight pop responses may be outstanding; ready drops past that.
// Reset is synchronous; the queue memory needs no clearing.
`default_nettype none
module dual_range_decimating_sampler (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [drds_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [drds_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   drds_req_if.sink                                  req_if,
   drds_rsp_if.source                                rsp_if
);

   drds_pkg::cfg_type    cfg;
   drds_pkg::push_type   push;
   drds_pkg::pop_type    pop;
   drds_pkg::result_type result;
   drds_pkg::entry_type  rsp_entry;
   logic                 accept;
   logic                 room;
   logic                 pop_take;

   assign req_if.ready = room;
   assign accept       = req_if.valid && room;
   assign pop_take     = accept && (req_if.req_type == drds_pkg::REQ_POP);

   drds_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .req_type    (req_if.req_type),
      .high_sample (req_if.high_sample),
      .low_sample  (req_if.low_sample),
      .cfg         (cfg),
      .push        (push),
      .pop         (pop)
   );

   drds_store u_store (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .push   (push),
      .pop    (pop),
      .result (result)
   );

   drds_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .credit_take (pop_take),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_entry   (rsp_entry),
      .room        (room)
   );

   assign rsp_if.value         = rsp_entry.value;
   assign rsp_if.queue_empty   = rsp_entry.queue_empty;
   assign rsp_if.overflow_seen = rsp_entry.overflow_seen;
   assign rsp_if.run_complete  = rsp_entry.run_complete;

endmodule
`default_nettype wire

[hdl/drds_checker.sv]
// Port-level checks of the sampler and their binding to the top level.
`default_nettype none
module drds_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [drds_pkg::REQ_BITS-1:0]     req_type,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [drds_pkg::VALUE_BITS-1:0]   rsp_value,
   input  wire logic                              rsp_queue_empty,
   input  wire logic                              rsp_overflow_seen,
   input  wire logic                              rsp_run_complete
);

   logic [drds_pkg::CREDIT_BITS-1:0] pending_ff, pending_in;
   logic                             pop_acc;
   logic                             rsp_acc;

   assign pop_acc = req_valid && req_ready && (req_type == drds_pkg::REQ_POP);
   assign rsp_acc = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + drds_pkg::CREDIT_BITS'(pop_acc)
                     - drds_pkg::CREDIT_BITS'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_needs_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response item without an outstanding pop");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> rsp_value == '0)
      else $error("empty pop item carries a nonzero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_queue_empty) && $stable(rsp_overflow_seen)
         && $stable(rsp_run_complete))
      else $error("stalled response item changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      pop_acc && pending_ff == '0 |=> !rsp_valid)
      else $error("pop item answered in the following cycle");

endmodule

bind dual_range_decimating_sampler drds_checker u_drds_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .req_type          (req_if.req_type),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_value         (rsp_if.value),
   .rsp_queue_empty   (rsp_if.queue_empty),
   .rsp_overflow_seen (rsp_if.overflow_seen),
   .rsp_run_complete  (rsp_if.run_complete)
);
`default_nettype wire
